### rtl/core/pesp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pesp_pkg
// Types and codes shared by the printer escape sequence parser modules.
// ----------------------------------------------------------------------------
package pesp_pkg;

  localparam int BYTE_W  = 8;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 12;
  localparam int TOTAL_W = 11;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INTL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GFX  = 2'd2;

  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'd27;

  // command codes
  localparam logic [BYTE_W-1:0] CMD_NONE     = 8'd0;
  localparam logic [BYTE_W-1:0] CMD_EXP_ON   = 8'd14;
  localparam logic [BYTE_W-1:0] CMD_EXP_OFF  = 8'd15;
  localparam logic [BYTE_W-1:0] CMD_INTL_ON  = 8'd23;
  localparam logic [BYTE_W-1:0] CMD_INTL_OFF = 8'd24;
  localparam logic [BYTE_W-1:0] CMD_UL_ON    = 8'd25;
  localparam logic [BYTE_W-1:0] CMD_UL_OFF   = 8'd26;
  localparam logic [BYTE_W-1:0] CMD_SPC_12   = 8'h36;  // '6'
  localparam logic [BYTE_W-1:0] CMD_SPC_8    = 8'h39;  // '9'
  localparam logic [BYTE_W-1:0] CMD_GFX      = 8'h41;  // 'A'

  // international remaps
  localparam logic [BYTE_W-1:0] INTL_OFFSET  = 8'hA0;
  localparam logic [BYTE_W-1:0] INTL_GRAVE   = 8'd96;
  localparam logic [BYTE_W-1:0] INTL_LBRACE  = 8'd123;
  localparam logic [BYTE_W-1:0] INTL_TILDE   = 8'd126;
  localparam logic [BYTE_W-1:0] INTL_DEL     = 8'd127;
  localparam logic [BYTE_W-1:0] MAP_GRAVE    = 8'd161;
  localparam logic [BYTE_W-1:0] MAP_LBRACE   = 8'd196;
  localparam logic [BYTE_W-1:0] MAP_TILDE    = 8'd182;
  localparam logic [BYTE_W-1:0] MAP_DEL      = 8'd171;

  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] code;
    logic              expanded;
    logic              underline;
    logic              spacing_tight;
  } pesp_result_t;

endpackage
`default_nettype wire

### rtl/core/pesp_in_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pesp_in_reg
// Input register stage: holds one received byte until the parser takes it.
// ----------------------------------------------------------------------------
module pesp_in_reg (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [pesp_pkg::BYTE_W-1:0] s_tdata,
  input  wire logic                       advance,
  output logic                            full,
  output logic [pesp_pkg::BYTE_W-1:0]     data_byte
);
  import pesp_pkg::*;

  // stage frees up in the same cycle its item moves on, nothing taken in reset
  assign s_tready = !rst && (!full || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tready) begin
      full <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      data_byte <= s_tdata;
    end
  end

endmodule
`default_nettype wire

### rtl/core/pesp_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pesp_parser
// Escape sequence state and mode flags, and the decode of one byte per step.
// ----------------------------------------------------------------------------
module pesp_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step,
  input  wire logic [pesp_pkg::BYTE_W-1:0] data_byte,
  output pesp_pkg::pesp_result_t           result
);
  import pesp_pkg::*;

  logic               escape_active, escape_active_next;
  logic [BYTE_W-1:0]  command_code, command_code_next;
  logic [CNT_W-1:0]   byte_counter, byte_counter_next;
  logic [BYTE_W-1:0]  count_low_byte, count_low_byte_next;
  logic [TOTAL_W-1:0] column_total, column_total_next;
  logic               expanded_flag, expanded_flag_next;
  logic               underline_flag, underline_flag_next;
  logic               international_flag, international_flag_next;
  logic               tight_spacing_flag, tight_spacing_flag_next;

  logic [BYTE_W-1:0]  cmd_eff;
  logic [CNT_W-1:0]   cnt_eff;
  logic [TOTAL_W-1:0] total_new;
  logic               end_seq;
  logic               is_intl_code;

  always_comb begin
    escape_active_next      = escape_active;
    command_code_next       = command_code;
    byte_counter_next       = byte_counter;
    count_low_byte_next     = count_low_byte;
    column_total_next       = column_total;
    expanded_flag_next      = expanded_flag;
    underline_flag_next     = underline_flag;
    international_flag_next = international_flag;
    tight_spacing_flag_next = tight_spacing_flag;
    end_seq                 = 1'b0;
    result.valid            = 1'b0;
    result.kind             = KIND_CHAR;
    result.code             = data_byte;
    result.expanded         = expanded_flag;
    result.underline        = underline_flag;
    result.spacing_tight    = tight_spacing_flag;

    // first byte after escape is the command, later ones are counted
    cmd_eff   = (command_code == CMD_NONE) ? data_byte : command_code;
    cnt_eff   = (command_code == CMD_NONE) ? '0 : byte_counter + CNT_W'(1);
    total_new = {data_byte[2:0], count_low_byte};
    is_intl_code = (data_byte < 8'd32) || (data_byte == INTL_GRAVE) ||
                   (data_byte == INTL_LBRACE) || (data_byte == INTL_TILDE) ||
                   (data_byte == INTL_DEL);

    if (escape_active) begin
      command_code_next = cmd_eff;
      byte_counter_next = cnt_eff;
      unique case (cmd_eff)
        CMD_EXP_ON: begin
          expanded_flag_next = 1'b1;
          end_seq = 1'b1;
        end
        CMD_EXP_OFF: begin
          expanded_flag_next = 1'b0;
          end_seq = 1'b1;
        end
        CMD_INTL_ON: begin
          international_flag_next = 1'b1;
          end_seq = 1'b1;
        end
        CMD_INTL_OFF: begin
          international_flag_next = 1'b0;
          end_seq = 1'b1;
        end
        CMD_UL_ON: begin
          underline_flag_next = 1'b1;
          end_seq = 1'b1;
        end
        CMD_UL_OFF: begin
          underline_flag_next = 1'b0;
          end_seq = 1'b1;
        end
        CMD_SPC_12: begin
          tight_spacing_flag_next = 1'b0;
          end_seq = 1'b1;
        end
        CMD_SPC_8: begin
          tight_spacing_flag_next = 1'b1;
          end_seq = 1'b1;
        end
        CMD_GFX: begin
          priority if (cnt_eff == CNT_W'(0)) begin
            // command byte itself
          end else if (cnt_eff == CNT_W'(1)) begin
            count_low_byte_next = data_byte;
          end else if (cnt_eff == CNT_W'(2)) begin
            column_total_next = total_new;
            end_seq = (total_new == '0);
          end else begin
            result.valid = 1'b1;
            result.kind  = KIND_GFX;
            result.code  = {1'b0, data_byte[6:0]};
            end_seq = (cnt_eff >= ({1'b0, column_total} + CNT_W'(2)));
          end
        end
        default: begin
          end_seq = 1'b1;
        end
      endcase
    end else if (data_byte == ESC_BYTE) begin
      escape_active_next = 1'b1;
    end else if (international_flag && is_intl_code) begin
      result.valid = 1'b1;
      priority if (data_byte < 8'd27) begin
        result.kind = KIND_INTL;
      end else if (data_byte < 8'd32) begin
        result.code = data_byte + INTL_OFFSET;
      end else if (data_byte == INTL_GRAVE) begin
        result.code = MAP_GRAVE;
      end else if (data_byte == INTL_LBRACE) begin
        result.code = MAP_LBRACE;
      end else if (data_byte == INTL_TILDE) begin
        result.code = MAP_TILDE;
      end else begin
        result.code = MAP_DEL;
      end
    end else if (data_byte > 8'd31 && data_byte < 8'd127) begin
      result.valid = 1'b1;
    end

    if (end_seq) begin
      escape_active_next  = 1'b0;
      command_code_next   = CMD_NONE;
      byte_counter_next   = '0;
      count_low_byte_next = '0;
      column_total_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_active      <= 1'b0;
      command_code       <= CMD_NONE;
      byte_counter       <= '0;
      count_low_byte     <= '0;
      column_total       <= '0;
      expanded_flag      <= 1'b0;
      underline_flag     <= 1'b0;
      international_flag <= 1'b0;
      tight_spacing_flag <= 1'b0;
    end else if (step) begin
      escape_active      <= escape_active_next;
      command_code       <= command_code_next;
      byte_counter       <= byte_counter_next;
      count_low_byte     <= count_low_byte_next;
      column_total       <= column_total_next;
      expanded_flag      <= expanded_flag_next;
      underline_flag     <= underline_flag_next;
      international_flag <= international_flag_next;
      tight_spacing_flag <= tight_spacing_flag_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/printer_escape_sequence_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// printer_escape_sequence_parser_unit
// Parses a host print byte stream into characters, table indexes and
// graphics columns, tracking the escape sequence state and print modes.
// ----------------------------------------------------------------------------
// datapath: input register, then one decode step into the result register
// throughput: one byte per cycle; a stalled result holds the input stage
// reset: synchronous rst clears the escape state, all mode flags and both
// stages; the first byte can be taken as soon as rst is low
module printer_escape_sequence_parser_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] code, [8] expanded, [9] underline,
                                      // [10] spacing_tight, [15:11] zero
  output logic [1:0]       m_tuser    // [1:0] kind
);
  import pesp_pkg::*;

  logic              in_full;
  logic [BYTE_W-1:0] in_byte;
  logic              advance;
  pesp_result_t      result;
  pesp_result_t      out_reg;

  // item moves into the result register when that register is empty or being read out
  assign advance = in_full && (!m_tvalid || m_tready);

  pesp_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .advance   (advance),
    .full      (in_full),
    .data_byte (in_byte)
  );

  pesp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (in_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= result.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {5'd0, out_reg.spacing_tight, out_reg.underline,
                    out_reg.expanded, out_reg.code};
  assign m_tuser = out_reg.kind;

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (in_full && m_tvalid && !m_tready) |-> !s_tready)
    else $error("input taken while both stages are held");

  a_intl_index_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_INTL) |-> (m_tdata[7:0] < 8'd27))
    else $error("table index out of range");

  a_gfx_seven_bits: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_GFX) |-> !m_tdata[7])
    else $error("graphics column wider than seven pins");

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == KIND_CHAR) |->
      (m_tdata[7:0] >= 8'd32 && (m_tdata[7:0] < 8'd127 || m_tdata[7:0] >= 8'd160)))
    else $error("character code out of range");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("held result changed");

endmodule
`default_nettype wire

### dv/pesp_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pesp_tb_pkg
// Tracks the printer parser's escape state and print modes from the bytes it
// accepts, and holds the symbols it should produce, oldest first.
// ----------------------------------------------------------------------------
package pesp_tb_pkg;
  import pesp_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] code;
    logic              expanded;
    logic              underline;
    logic              spacing_tight;
  } print_symbol_t;

  class print_stream_checker;
    print_symbol_t      pending_symbols[$];
    int unsigned        mismatches;

    logic               in_escape;
    logic [BYTE_W-1:0]  cmd;
    logic [CNT_W-1:0]   arg_count;
    logic [BYTE_W-1:0]  gfx_low;
    logic [TOTAL_W-1:0] gfx_total;
    logic               expanded;
    logic               underline;
    logic               intl;
    logic               tight;

    function new();
      mismatches = 0;
      expanded   = 1'b0;
      underline  = 1'b0;
      intl       = 1'b0;
      tight      = 1'b0;
      end_escape();
    endfunction

    function void end_escape();
      in_escape = 1'b0;
      cmd       = CMD_NONE;
      arg_count = '0;
      gfx_low   = '0;
      gfx_total = '0;
    endfunction

    // flags are taken as they stand after the byte is applied
    function void add_symbol(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] code);
      print_symbol_t s;
      s.kind          = kind;
      s.code          = code;
      s.expanded      = expanded;
      s.underline     = underline;
      s.spacing_tight = tight;
      pending_symbols.push_back(s);
    endfunction

    function void take_byte(logic [BYTE_W-1:0] c);
      if (in_escape) begin
        if (cmd == CMD_NONE) begin
          cmd       = c;
          arg_count = '0;
        end else begin
          arg_count = arg_count + 1'b1;
        end
        case (cmd)
          CMD_EXP_ON:   begin expanded  = 1'b1; end_escape(); end
          CMD_EXP_OFF:  begin expanded  = 1'b0; end_escape(); end
          CMD_INTL_ON:  begin intl      = 1'b1; end_escape(); end
          CMD_INTL_OFF: begin intl      = 1'b0; end_escape(); end
          CMD_UL_ON:    begin underline = 1'b1; end_escape(); end
          CMD_UL_OFF:   begin underline = 1'b0; end_escape(); end
          CMD_SPC_12:   begin tight     = 1'b0; end_escape(); end
          CMD_SPC_8:    begin tight     = 1'b1; end_escape(); end
          CMD_GFX: begin
            if (arg_count == 1) begin
              gfx_low = c;
            end else if (arg_count == 2) begin
              gfx_total = {c[2:0], gfx_low};
              if (gfx_total == 0) end_escape();
            end else if (arg_count > 2) begin
              add_symbol(KIND_GFX, {1'b0, c[6:0]});
              if (32'(arg_count) >= 32'(gfx_total) + 2) end_escape();
            end
          end
          default: end_escape();
        endcase
      end else if (c == ESC_BYTE) begin
        in_escape = 1'b1;
      end else if (intl && (c < 8'd32 || c == INTL_GRAVE || c == INTL_LBRACE ||
                            c == INTL_TILDE || c == INTL_DEL)) begin
        if (c < ESC_BYTE)       add_symbol(KIND_INTL, c);
        else if (c < 8'd32)     add_symbol(KIND_CHAR, c + INTL_OFFSET);
        else if (c == INTL_GRAVE)  add_symbol(KIND_CHAR, MAP_GRAVE);
        else if (c == INTL_LBRACE) add_symbol(KIND_CHAR, MAP_LBRACE);
        else if (c == INTL_TILDE)  add_symbol(KIND_CHAR, MAP_TILDE);
        else                       add_symbol(KIND_CHAR, MAP_DEL);
      end else if (c > 8'd31 && c < 8'd127) begin
        add_symbol(KIND_CHAR, c);
      end
    endfunction

    function void match_symbol(print_symbol_t got, logic [4:0] pad);
      print_symbol_t want;
      if (pending_symbols.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item kind=%0d code=%02h exp=%b ul=%b tight=%b",
                 $realtime, got.kind, got.code, got.expanded, got.underline,
                 got.spacing_tight);
        return;
      end
      want = pending_symbols.pop_front();
      if (got !== want || pad !== 5'd0) begin
        mismatches++;
        $display("%0t: mismatch expected kind=%0d code=%02h exp=%b ul=%b tight=%b pad=0",
                 $realtime, want.kind, want.code, want.expanded, want.underline,
                 want.spacing_tight);
        $display("%0t:          actual   kind=%0d code=%02h exp=%b ul=%b tight=%b pad=%0h",
                 $realtime, got.kind, got.code, got.expanded, got.underline,
                 got.spacing_tight, pad);
      end
    endfunction
  endclass

endpackage

### dv/printer_escape_sequence_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printer_escape_sequence_parser_unit_tb
// Feeds the parser directed and random print streams (mode commands, graphics
// runs, international remaps, broken sequences) with random gaps on both
// sides and checks every output item against a running prediction.
// ----------------------------------------------------------------------------
module printer_escape_sequence_parser_unit_tb;
  import pesp_pkg::*;
  import pesp_tb_pkg::*;

  localparam int RANDOM_BYTES = 550;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;

  int unsigned send_gap_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned cycles        = 0;

  print_stream_checker chk = new();

  printer_escape_sequence_parser_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    print_symbol_t got;
    got.kind          = m_tuser;
    got.code          = m_tdata[7:0];
    got.expanded      = m_tdata[8];
    got.underline     = m_tdata[9];
    got.spacing_tight = m_tdata[10];
    if (!rst && m_tvalid && m_tready) chk.match_symbol(got, m_tdata[15:11]);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("printer_escape_sequence_parser_unit_tb: done, errors");
      $finish;
    end
  end

  task automatic put_byte(logic [7:0] b);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    chk.take_byte(b);
    bytes_sent++;
  endtask

  function automatic logic [7:0] mode_cmd(int unsigned idx);
    case (idx)
      0:       return CMD_EXP_ON;
      1:       return CMD_EXP_OFF;
      2:       return CMD_INTL_ON;
      3:       return CMD_INTL_OFF;
      4:       return CMD_UL_ON;
      5:       return CMD_UL_OFF;
      6:       return CMD_SPC_12;
      default: return CMD_SPC_8;
    endcase
  endfunction

  task automatic put_graphics(logic [7:0] n1, logic [7:0] n2);
    int unsigned cols;
    cols = {n2[2:0], n1};
    put_byte(ESC_BYTE);
    put_byte(CMD_GFX);
    put_byte(n1);
    put_byte(n2);
    repeat (cols) put_byte(8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned r;
    int unsigned start;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: plain bytes, each mode, international remaps, graphics edges
    put_byte(8'd32);
    put_byte(8'd126);
    put_byte(8'd255);
    put_byte(ESC_BYTE); put_byte(CMD_EXP_ON);
    put_byte(ESC_BYTE); put_byte(CMD_UL_ON);
    put_byte(ESC_BYTE); put_byte(CMD_SPC_8);
    put_byte(ESC_BYTE); put_byte(CMD_INTL_ON);
    put_byte(8'd0);
    put_byte(8'd26);
    put_byte(8'd28);
    put_byte(8'd31);
    put_byte(INTL_GRAVE);
    put_byte(INTL_LBRACE);
    put_byte(INTL_TILDE);
    put_byte(INTL_DEL);
    put_graphics(8'd1, 8'h08);  // upper count bits dropped
    put_graphics(8'd0, 8'hF8);  // zero count ends at once
    put_byte(ESC_BYTE); put_byte(CMD_NONE);
    put_byte(ESC_BYTE); put_byte(ESC_BYTE);

    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      if (bytes_sent - start < RANDOM_BYTES / 3) begin
        send_gap_pct = 19; recv_stall_pct = 75;
      end else if (bytes_sent - start < 2 * RANDOM_BYTES / 3) begin
        send_gap_pct = 75; recv_stall_pct = 19;
      end else begin
        send_gap_pct = 0; recv_stall_pct = 0;
      end
      r = $urandom_range(99);
      if (r < 25) begin
        put_byte(8'($urandom_range(255)));
      end else if (r < 45) begin
        put_byte(8'($urandom_range(126, 32)));
      end else if (r < 70) begin
        put_byte(ESC_BYTE);
        put_byte(mode_cmd($urandom_range(7)));
      end else if (r < 90) begin
        // mostly short runs, once in a while a long one that fits the bytes left
        if ($urandom_range(60) == 0 && RANDOM_BYTES - (bytes_sent - start) > 260)
          put_graphics(8'($urandom_range(255)), {5'($urandom_range(31)), 3'b000});
        else
          put_graphics(8'($urandom_range(5)), {5'($urandom_range(31)), 3'b000});
      end else if (r < 95) begin
        put_byte(ESC_BYTE);
        put_byte(8'($urandom_range(255)));
      end else begin
        // graphics header cut short, following bytes get swallowed as arguments
        put_byte(ESC_BYTE);
        put_byte(CMD_GFX);
        put_byte(8'($urandom_range(3)));
      end
    end
    s_tvalid <= 1'b0;
    send_gap_pct = 0; recv_stall_pct = 0;

    while (chk.pending_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (chk.mismatches == 0)
      $display("printer_escape_sequence_parser_unit_tb: done, clean");
    else
      $display("printer_escape_sequence_parser_unit_tb: done, errors");
    $finish;
  end

endmodule

### sim.f
rtl/core/pesp_pkg.sv
rtl/core/pesp_in_reg.sv
rtl/core/pesp_parser.sv
rtl/core/printer_escape_sequence_parser_unit.sv
dv/pesp_tb_pkg.sv
dv/printer_escape_sequence_parser_unit_tb.sv
